// ===== hdl/assert_macros.svh =====
// Assertion helpers, included by the unit that checks its own logic.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define WAVP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A condition in one cycle that implies another in the cycle after.
`define WAVP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        ((ante) |=> (cons))) else $error(msg);

`endif

// ===== hdl/wavp_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV parser package
// Word and phase types, result codes, header tags, sample depths and header byte positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wavp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [15:0] audio_format;
        logic [15:0] channels;
        logic [31:0] rate_hz;
        logic [31:0] bytes_per_sec;
        logic [15:0] frame_stride;
        logic [15:0] sample_bits;
        logic [15:0] channel;
        logic [31:0] frame_index;
        logic [31:0] sample;
        logic        last;
    } t_out_word;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_DATA   = 3'b010,
        PH_IDLE   = 3'b100
    } t_phase;

    localparam logic [1:0] KIND_ERROR  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_BAD_RIFF = 3'd1;
    localparam logic [2:0] STATUS_BAD_WAVE = 3'd2;
    localparam logic [2:0] STATUS_BAD_FMT  = 3'd3;
    localparam logic [2:0] STATUS_BAD_DATA = 3'd4;
    localparam logic [2:0] STATUS_BAD_FORM = 3'd5;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] DEPTH_8  = 16'd8;
    localparam logic [15:0] DEPTH_16 = 16'd16;
    localparam logic [15:0] DEPTH_32 = 16'd32;

    localparam logic [5:0] POS_RIFF_END   = 6'd3;
    localparam logic [5:0] POS_WAVE_END   = 6'd11;
    localparam logic [5:0] POS_FMT_END    = 6'd15;
    localparam logic [5:0] POS_FORMAT_END = 6'd21;
    localparam logic [5:0] POS_CHAN_END   = 6'd23;
    localparam logic [5:0] POS_RATE_END   = 6'd27;
    localparam logic [5:0] POS_BRATE_END  = 6'd31;
    localparam logic [5:0] POS_ALIGN_END  = 6'd33;
    localparam logic [5:0] POS_DEPTH_END  = 6'd35;
    localparam logic [5:0] POS_DATA_END   = 6'd39;
    localparam logic [5:0] POS_SIZE_END   = 6'd43;

endpackage

`default_nettype wire

// ===== hdl/wavp_in_stage.sv =====
// ----------------------------------------------------------------------------
// WAV parser input register
// Holds one accepted word until the parser consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wavp_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire wavp_pkg::t_in_word i_word,
    input  wire                 i_advance,
    output logic                o_valid,
    output wavp_pkg::t_in_word  o_word
);

    logic               r_valid;
    wavp_pkg::t_in_word r_word;

    assign o_stall = r_valid & ~i_advance;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wavp_parse.sv =====
// ----------------------------------------------------------------------------
// WAV parser core
// Header walk, tag and format checks, and little-endian sample assembly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wavp_parse (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  wire wavp_pkg::t_in_word i_word,
    output logic                o_res_valid,
    output wavp_pkg::t_out_word o_res
);

    wavp_pkg::t_phase r_phase, n_phase;
    logic [5:0]       r_pos, n_pos;
    logic [31:0]      r_field_shift, n_field_shift;
    logic [15:0]      r_format_code, n_format_code;
    logic [15:0]      r_channel_total, n_channel_total;
    logic [31:0]      r_rate_value, n_rate_value;
    logic [31:0]      r_bytes_per_second, n_bytes_per_second;
    logic [15:0]      r_frame_bytes, n_frame_bytes;
    logic [15:0]      r_depth_bits, n_depth_bits;
    logic [31:0]      r_data_left, n_data_left;
    logic [1:0]       r_byte_count, n_byte_count;
    logic [15:0]      r_channel_count, n_channel_count;
    logic [31:0]      r_frame_count, n_frame_count;

    wavp_pkg::t_phase cur_phase;
    logic [5:0]       cur_pos;
    logic [31:0]      hdr_shift;
    logic [17:0]      frame_size;
    logic [2:0]       bytes_per_sample;
    logic [2:0]       count_inc;
    logic [15:0]      channel_inc;
    logic             depth_bad;

    always_comb begin
        cur_phase = i_word.first ? wavp_pkg::PH_HEADER : r_phase;
        cur_pos   = i_word.first ? 6'd0 : r_pos;
        hdr_shift = {i_word.data_byte, r_field_shift[31:8]};

        if (r_depth_bits == wavp_pkg::DEPTH_32) begin
            frame_size = {r_channel_total, 2'b00};
        end else if (r_depth_bits == wavp_pkg::DEPTH_16) begin
            frame_size = {1'b0, r_channel_total, 1'b0};
        end else begin
            frame_size = {2'b00, r_channel_total};
        end

        bytes_per_sample = r_depth_bits[5:3];
        count_inc        = {1'b0, r_byte_count} + 3'd1;
        channel_inc      = r_channel_count + 16'd1;
        depth_bad        = (r_depth_bits != wavp_pkg::DEPTH_8) &&
                           (r_depth_bits != wavp_pkg::DEPTH_16) &&
                           (r_depth_bits != wavp_pkg::DEPTH_32);

        n_phase            = cur_phase;
        n_pos              = cur_pos;
        n_field_shift      = r_field_shift;
        n_format_code      = r_format_code;
        n_channel_total    = r_channel_total;
        n_rate_value       = r_rate_value;
        n_bytes_per_second = r_bytes_per_second;
        n_frame_bytes      = r_frame_bytes;
        n_depth_bits       = r_depth_bits;
        n_data_left        = r_data_left;
        n_byte_count       = r_byte_count;
        n_channel_count    = r_channel_count;
        n_frame_count      = r_frame_count;
        o_res_valid        = 1'b0;
        o_res              = '0;

        unique case (cur_phase)
            wavp_pkg::PH_HEADER: begin
                n_field_shift = hdr_shift;
                n_pos         = cur_pos + 6'd1;
                unique case (cur_pos)
                    wavp_pkg::POS_RIFF_END: begin
                        if (hdr_shift != wavp_pkg::TAG_RIFF) begin
                            o_res_valid  = 1'b1;
                            o_res.status = wavp_pkg::STATUS_BAD_RIFF;
                            n_phase      = wavp_pkg::PH_IDLE;
                        end
                    end
                    wavp_pkg::POS_WAVE_END: begin
                        if (hdr_shift != wavp_pkg::TAG_WAVE) begin
                            o_res_valid  = 1'b1;
                            o_res.status = wavp_pkg::STATUS_BAD_WAVE;
                            n_phase      = wavp_pkg::PH_IDLE;
                        end
                    end
                    wavp_pkg::POS_FMT_END: begin
                        if (hdr_shift != wavp_pkg::TAG_FMT) begin
                            o_res_valid  = 1'b1;
                            o_res.status = wavp_pkg::STATUS_BAD_FMT;
                            n_phase      = wavp_pkg::PH_IDLE;
                        end
                    end
                    wavp_pkg::POS_FORMAT_END: n_format_code      = hdr_shift[31:16];
                    wavp_pkg::POS_CHAN_END:   n_channel_total    = hdr_shift[31:16];
                    wavp_pkg::POS_RATE_END:   n_rate_value       = hdr_shift;
                    wavp_pkg::POS_BRATE_END:  n_bytes_per_second = hdr_shift;
                    wavp_pkg::POS_ALIGN_END:  n_frame_bytes      = hdr_shift[31:16];
                    wavp_pkg::POS_DEPTH_END:  n_depth_bits       = hdr_shift[31:16];
                    wavp_pkg::POS_DATA_END: begin
                        if (hdr_shift != wavp_pkg::TAG_DATA) begin
                            o_res_valid  = 1'b1;
                            o_res.status = wavp_pkg::STATUS_BAD_DATA;
                            n_phase      = wavp_pkg::PH_IDLE;
                        end
                    end
                    wavp_pkg::POS_SIZE_END: begin
                        n_data_left = hdr_shift;
                        o_res_valid = 1'b1;
                        if (depth_bad || (r_channel_total == 16'd0)) begin
                            o_res.status = wavp_pkg::STATUS_BAD_FORM;
                            n_phase      = wavp_pkg::PH_IDLE;
                        end else begin
                            o_res.kind          = wavp_pkg::KIND_HEADER;
                            o_res.status        = wavp_pkg::STATUS_OK;
                            o_res.audio_format  = r_format_code;
                            o_res.channels      = r_channel_total;
                            o_res.rate_hz       = r_rate_value;
                            o_res.bytes_per_sec = r_bytes_per_second;
                            o_res.frame_stride  = r_frame_bytes;
                            o_res.sample_bits   = r_depth_bits;
                            n_byte_count        = 2'd0;
                            n_channel_count     = 16'd0;
                            n_frame_count       = 32'd0;
                            if (hdr_shift < {14'd0, frame_size}) begin
                                n_phase = wavp_pkg::PH_IDLE;
                            end else begin
                                n_phase = wavp_pkg::PH_DATA;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            wavp_pkg::PH_DATA: begin
                case (r_byte_count)
                    2'd0:    n_field_shift = {24'd0, i_word.data_byte};
                    2'd1:    n_field_shift = r_field_shift | {16'd0, i_word.data_byte, 8'd0};
                    2'd2:    n_field_shift = r_field_shift | {8'd0, i_word.data_byte, 16'd0};
                    default: n_field_shift = r_field_shift | {i_word.data_byte, 24'd0};
                endcase
                n_data_left = r_data_left - 32'd1;
                if (count_inc < bytes_per_sample) begin
                    n_byte_count = count_inc[1:0];
                end else begin
                    n_byte_count      = 2'd0;
                    o_res_valid       = 1'b1;
                    o_res.kind        = wavp_pkg::KIND_SAMPLE;
                    o_res.status      = wavp_pkg::STATUS_OK;
                    o_res.channel     = r_channel_count;
                    o_res.frame_index = r_frame_count;
                    o_res.sample      = n_field_shift;
                    if (channel_inc == r_channel_total) begin
                        n_channel_count = 16'd0;
                        n_frame_count   = r_frame_count + 32'd1;
                        // One byte is taken here, so the remainder falls
                        // short of a frame when the count held no more than one.
                        if (r_data_left <= {14'd0, frame_size}) begin
                            o_res.last = 1'b1;
                            n_phase    = wavp_pkg::PH_IDLE;
                        end
                    end else begin
                        n_channel_count = channel_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wavp_pkg::PH_HEADER;
            r_pos   <= 6'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_field_shift      <= n_field_shift;
            r_format_code      <= n_format_code;
            r_channel_total    <= n_channel_total;
            r_rate_value       <= n_rate_value;
            r_bytes_per_second <= n_bytes_per_second;
            r_frame_bytes      <= n_frame_bytes;
            r_depth_bits       <= n_depth_bits;
            r_data_left        <= n_data_left;
            r_byte_count       <= n_byte_count;
            r_channel_count    <= n_channel_count;
            r_frame_count      <= n_frame_count;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wavp_out_stage.sv =====
// ----------------------------------------------------------------------------
// WAV parser result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wavp_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wire wavp_pkg::t_out_word i_word,
    output logic                o_advance,
    output logic                o_valid,
    input  wire                 i_stall,
    output wavp_pkg::t_out_word o_word
);

    logic                r_valid;
    wavp_pkg::t_out_word r_word;

    assign o_advance = ~r_valid | ~i_stall;
    assign o_valid   = r_valid;
    assign o_word    = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wav_header_parser_sample_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// WAV header parser and sample unpacker
// Parses the canonical 44-byte WAV header and emits a header word and PCM samples, or an error word.
// ----------------------------------------------------------------------------
// The block takes one byte word per clock cycle, with no gaps of its own,
// and the byte that causes a result word passes through the input register
// and the parser, which writes the word into the result register. The only
// limit on rate is the single parser pass per byte; a stall on the result
// side holds the input side once both registers are full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wav_header_parser_sample_unpacker_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire wavp_pkg::t_in_word i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output wavp_pkg::t_out_word o_out_word
);

    logic                w_in_valid;
    wavp_pkg::t_in_word  w_in_word;
    logic                w_advance;
    logic                w_fire;
    logic                w_res_valid;
    wavp_pkg::t_out_word w_res;
    logic                w_out_sample;
    logic                w_out_last;
    logic                w_status_ok;
    logic                w_held;

    assign w_fire = w_in_valid & w_advance;

    wavp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_word    (i_in_word),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_word    (w_in_word)
    );

    wavp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_word      (w_in_word),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wavp_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_fire & w_res_valid),
        .i_word    (w_res),
        .o_advance (w_advance),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_word    (o_out_word)
    );

    assign w_out_sample = o_out_valid && (o_out_word.kind == wavp_pkg::KIND_SAMPLE);
    assign w_out_last   = o_out_valid && o_out_word.last;
    assign w_status_ok  = (o_out_word.status == wavp_pkg::STATUS_OK);
    assign w_held       = w_in_valid && !w_advance;

    `WAVP_ASSERT(a_sample_ok, w_out_sample |-> w_status_ok, "Sample word with an error status.")
    `WAVP_ASSERT(a_last_on_sample, w_out_last |-> w_out_sample, "Last flag on a non-sample word.")
    `WAVP_ASSERT_NEXT(a_held_byte_kept, w_held, w_in_valid, "Held byte dropped under a stall.")

endmodule

`default_nettype wire

// ===== sim/wav_header_parser_sample_unpacker_unit_test.sv =====
// ----------------------------------------------------------------------------
// WAV header parser and sample unpacker testbench
// Feeds byte words made of whole and broken WAV files, predicts the result
// words from an independent model of the parser, apart from those pinned in
// the directed rows, and checks each result word field by field, with random
// idling on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wav_header_parser_sample_unpacker_unit_test;

    localparam int RANDOM_BYTES   = 600;
    localparam int CALM_FROM      = 250;
    localparam int CALM_TO        = 400;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HEADER_BYTES   = 44;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       pinned;
        logic [1:0] kind;
        logic [2:0] status;
    } t_step;

    // A pinned row carries its result word here; the others are predicted.
    localparam t_step DIRECTED [22] = '{
        '{8'h00, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b1, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_BAD_RIFF},
        '{8'hFF, 1'b1, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b1, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_BAD_RIFF},
        '{8'hFF, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h00, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h52, 1'b1, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h49, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h46, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h46, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h57, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h41, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h56, 1'b0, 1'b0, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_OK},
        '{8'h58, 1'b0, 1'b1, wavp_pkg::KIND_ERROR, wavp_pkg::STATUS_BAD_WAVE}
    };

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_out_stall = 1'b0;
    wavp_pkg::t_in_word  i_in_word   = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    wavp_pkg::t_out_word o_out_word;

    wavp_pkg::t_out_word expected_words [$];
    int                  error_count = 0;
    int                  bytes_sent  = 0;
    bit                  calm        = 1'b0;

    wavp_pkg::t_phase parse_phase;
    logic [5:0]  hdr_pos;
    logic [31:0] shift_reg;
    logic [15:0] fmt_code;
    logic [15:0] chan_total;
    logic [31:0] rate;
    logic [31:0] bytes_sec;
    logic [15:0] blk_align;
    logic [15:0] depth;
    logic [31:0] bytes_left;
    logic [1:0]  byte_no;
    logic [15:0] chan_no;
    logic [31:0] frame_no;

    wav_header_parser_sample_unpacker_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic compare_word(input wavp_pkg::t_out_word got,
                                input wavp_pkg::t_out_word want);
        check_field("kind",          32'(got.kind),         32'(want.kind));
        check_field("status",        32'(got.status),       32'(want.status));
        check_field("audio_format",  32'(got.audio_format), 32'(want.audio_format));
        check_field("channels",      32'(got.channels),     32'(want.channels));
        check_field("rate_hz",       got.rate_hz,           want.rate_hz);
        check_field("bytes_per_sec", got.bytes_per_sec,     want.bytes_per_sec);
        check_field("frame_stride",  32'(got.frame_stride), 32'(want.frame_stride));
        check_field("sample_bits",   32'(got.sample_bits),  32'(want.sample_bits));
        check_field("channel",       32'(got.channel),      32'(want.channel));
        check_field("frame_index",   got.frame_index,       want.frame_index);
        check_field("sample",        got.sample,            want.sample);
        check_field("last",          32'(got.last),         32'(want.last));
    endtask

    task automatic reset_parser();
        parse_phase = wavp_pkg::PH_HEADER;
        hdr_pos     = '0;
        shift_reg   = '0;
        fmt_code    = '0;
        chan_total  = '0;
        rate        = '0;
        bytes_sec   = '0;
        blk_align   = '0;
        depth       = '0;
        bytes_left  = '0;
        byte_no     = '0;
        chan_no     = '0;
        frame_no    = '0;
    endtask

    function automatic logic [31:0] frame_length();
        return {16'd0, chan_total} * {19'd0, depth[15:3]};
    endfunction

    function automatic wavp_pkg::t_out_word error_word(input logic [2:0] code);
        wavp_pkg::t_out_word w;
        w        = '0;
        w.kind   = wavp_pkg::KIND_ERROR;
        w.status = code;
        parse_phase = wavp_pkg::PH_IDLE;
        return w;
    endfunction

    task automatic parse_byte(input wavp_pkg::t_in_word w, output logic has,
                              output wavp_pkg::t_out_word r);
        logic [5:0]  pos;
        logic [31:0] bps;
        has = 1'b0;
        r   = '0;
        if (w.first) begin
            reset_parser();
        end
        case (parse_phase)
            wavp_pkg::PH_HEADER: begin
                shift_reg = {w.data_byte, shift_reg[31:8]};
                pos       = hdr_pos;
                hdr_pos   = hdr_pos + 6'd1;
                case (pos)
                    wavp_pkg::POS_RIFF_END: if (shift_reg != wavp_pkg::TAG_RIFF) begin
                        has = 1'b1;
                        r   = error_word(wavp_pkg::STATUS_BAD_RIFF);
                    end
                    wavp_pkg::POS_WAVE_END: if (shift_reg != wavp_pkg::TAG_WAVE) begin
                        has = 1'b1;
                        r   = error_word(wavp_pkg::STATUS_BAD_WAVE);
                    end
                    wavp_pkg::POS_FMT_END: if (shift_reg != wavp_pkg::TAG_FMT) begin
                        has = 1'b1;
                        r   = error_word(wavp_pkg::STATUS_BAD_FMT);
                    end
                    wavp_pkg::POS_FORMAT_END: fmt_code   = shift_reg[31:16];
                    wavp_pkg::POS_CHAN_END:   chan_total = shift_reg[31:16];
                    wavp_pkg::POS_RATE_END:   rate       = shift_reg;
                    wavp_pkg::POS_BRATE_END:  bytes_sec  = shift_reg;
                    wavp_pkg::POS_ALIGN_END:  blk_align  = shift_reg[31:16];
                    wavp_pkg::POS_DEPTH_END:  depth      = shift_reg[31:16];
                    wavp_pkg::POS_DATA_END: if (shift_reg != wavp_pkg::TAG_DATA) begin
                        has = 1'b1;
                        r   = error_word(wavp_pkg::STATUS_BAD_DATA);
                    end
                    wavp_pkg::POS_SIZE_END: begin
                        bytes_left = shift_reg;
                        has        = 1'b1;
                        if ((depth != wavp_pkg::DEPTH_8 && depth != wavp_pkg::DEPTH_16
                                && depth != wavp_pkg::DEPTH_32) || chan_total == 16'd0) begin
                            r = error_word(wavp_pkg::STATUS_BAD_FORM);
                        end else begin
                            r.kind          = wavp_pkg::KIND_HEADER;
                            r.status        = wavp_pkg::STATUS_OK;
                            r.audio_format  = fmt_code;
                            r.channels      = chan_total;
                            r.rate_hz       = rate;
                            r.bytes_per_sec = bytes_sec;
                            r.frame_stride  = blk_align;
                            r.sample_bits   = depth;
                            byte_no  = '0;
                            chan_no  = '0;
                            frame_no = '0;
                            if (bytes_left < frame_length()) begin
                                parse_phase = wavp_pkg::PH_IDLE;
                            end else begin
                                parse_phase = wavp_pkg::PH_DATA;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            wavp_pkg::PH_DATA: begin
                bps = {19'd0, depth[15:3]};
                if (byte_no == 2'd0) begin
                    shift_reg = {24'd0, w.data_byte};
                end else begin
                    shift_reg = shift_reg | ({24'd0, w.data_byte} << (8 * byte_no));
                end
                bytes_left = bytes_left - 32'd1;
                if ({30'd0, byte_no} + 32'd1 < bps) begin
                    byte_no = byte_no + 2'd1;
                end else begin
                    byte_no       = 2'd0;
                    has           = 1'b1;
                    r.kind        = wavp_pkg::KIND_SAMPLE;
                    r.channel     = chan_no;
                    r.frame_index = frame_no;
                    r.sample      = shift_reg;
                    chan_no       = chan_no + 16'd1;
                    if (chan_no == chan_total) begin
                        chan_no  = '0;
                        frame_no = frame_no + 32'd1;
                        if (bytes_left < frame_length()) begin
                            r.last      = 1'b1;
                            parse_phase = wavp_pkg::PH_IDLE;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic f,
                             output logic has, output wavp_pkg::t_out_word r);
        wavp_pkg::t_in_word w;
        w = '{data_byte: b, first: f};
        while (!calm && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        bytes_sent++;
        calm = (bytes_sent >= CALM_FROM && bytes_sent < CALM_TO);
        parse_byte(w, has, r);
    endtask

    task automatic feed(input logic [7:0] b, input logic f);
        logic                has;
        wavp_pkg::t_out_word r;
        send_byte(b, f, has, r);
        if (has) begin
            expected_words.push_back(r);
        end
    endtask

    function automatic logic [351:0] make_header(input logic [15:0] chans,
                                                 input logic [15:0] bits,
                                                 input logic [31:0] payload_len);
        logic [351:0] h;
        h            = '0;
        h[0   +: 32] = wavp_pkg::TAG_RIFF;
        h[32  +: 32] = $urandom();
        h[64  +: 32] = wavp_pkg::TAG_WAVE;
        h[96  +: 32] = wavp_pkg::TAG_FMT;
        h[128 +: 32] = $urandom();
        h[160 +: 16] = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'd1;
        h[176 +: 16] = chans;
        h[192 +: 32] = $urandom();
        h[224 +: 32] = $urandom();
        h[256 +: 16] = 16'($urandom());
        h[272 +: 16] = bits;
        h[288 +: 32] = wavp_pkg::TAG_DATA;
        h[320 +: 32] = payload_len;
        return h;
    endfunction

    task automatic send_part(input logic [351:0] h, input int count);
        for (int i = 0; i < count; i++) begin
            if (i < HEADER_BYTES) begin
                feed(h[8*i +: 8], i == 0);
            end else begin
                feed(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    task automatic send_file();
        int           roll;
        int           extra;
        int           tag_start;
        int           tag_at [4] = '{0, 8, 12, 36};
        logic [15:0]  chans;
        logic [15:0]  bits;
        logic [31:0]  payload_len;
        logic [351:0] h;
        roll  = $urandom_range(99);
        chans = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 3));
        case ($urandom_range(2))
            0:       bits = wavp_pkg::DEPTH_8;
            1:       bits = wavp_pkg::DEPTH_16;
            default: bits = wavp_pkg::DEPTH_32;
        endcase
        case ($urandom_range(9))
            0:       payload_len = 32'hFFFF_FFFF;
            1:       payload_len = $urandom();
            default: payload_len = 32'($urandom_range(24));
        endcase
        if (roll < 55) begin
            send_part(make_header(chans, bits, payload_len), HEADER_BYTES);
            extra = (payload_len <= 32'd24) ? int'(payload_len) + int'($urandom_range(4))
                                            : int'($urandom_range(4, 30));
            repeat (extra) feed(8'($urandom_range(255)), 1'b0);
        end else if (roll < 70) begin
            tag_start = tag_at[$urandom_range(3)];
            h = make_header(chans, bits, payload_len);
            h[8*(tag_start + int'($urandom_range(3))) +: 8] ^= 8'($urandom_range(1, 255));
            send_part(h, tag_start + 4 + int'($urandom_range(3)));
        end else if (roll < 80) begin
            if ($urandom_range(1) == 0) begin
                chans = 16'd0;
            end else begin
                case ($urandom_range(3))
                    0:       bits = 16'd0;
                    1:       bits = 16'd24;
                    2:       bits = 16'hFFFF;
                    default: bits = 16'($urandom());
                endcase
            end
            send_part(make_header(chans, bits, payload_len),
                      HEADER_BYTES + int'($urandom_range(3)));
        end else if (roll < 90) begin
            send_part(make_header(chans, bits, payload_len), int'($urandom_range(1, 43)));
        end else begin
            repeat ($urandom_range(1, 10)) begin
                feed(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_error($sformatf("unexpected result word of kind %0d",
                                       o_out_word.kind));
            end else begin
                compare_word(o_out_word, expected_words.pop_front());
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 11);
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic                has;
        wavp_pkg::t_out_word r;
        wavp_pkg::t_out_word pinned_word;
        reset_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < $size(DIRECTED); i++) begin
            send_byte(DIRECTED[i].data_byte, DIRECTED[i].first, has, r);
            if (DIRECTED[i].pinned) begin
                pinned_word        = '0;
                pinned_word.kind   = DIRECTED[i].kind;
                pinned_word.status = DIRECTED[i].status;
                expected_words.push_back(pinned_word);
            end else if (has) begin
                expected_words.push_back(r);
            end
        end
        while (bytes_sent < $size(DIRECTED) + RANDOM_BYTES) begin
            send_file();
        end
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/wavp_pkg.sv
hdl/wavp_in_stage.sv
hdl/wavp_parse.sv
hdl/wavp_out_stage.sv
hdl/wav_header_parser_sample_unpacker_unit.sv
sim/wav_header_parser_sample_unpacker_unit_test.sv
